// ===== rtl/core/m4t_pkg.sv =====
// package: shared constants, codes and control types of the matrix transform unit
`default_nettype none
package m4t_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  // floored product fits 64 - FRAC_BITS bits, four of them two more
  localparam int ACC_W     = 2 * DATA_W - FRAC_BITS + 2;

  localparam logic signed [DATA_W-1:0] ONE_FX = DATA_W'(64'sd1 <<< FRAC_BITS);

  localparam logic [2:0] CMD_WR_CUR = 3'd0;
  localparam logic [2:0] CMD_WR_OPD = 3'd1;
  localparam logic [2:0] CMD_IDENT  = 3'd2;
  localparam logic [2:0] CMD_SETPOS = 3'd3;
  localparam logic [2:0] CMD_TRANS  = 3'd4;
  localparam logic [2:0] CMD_MUL    = 3'd5;
  localparam logic [2:0] CMD_XFORM  = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FLUSH,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic       load;
    logic       issue;
    logic [1:0] col;
    logic [1:0] k;
    logic       finish;
  } ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/m4t_dp.sv =====
// datapath: matrix registers, four mac lanes, result buffer and output register
`default_nettype none
module m4t_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  m4t_pkg::ctrl_t      ctrl_i,
  input  logic [2:0]          cmd_i,
  input  logic [3:0]          idx_i,
  input  logic signed [31:0]  value_a_i,
  input  logic signed [31:0]  value_b_i,
  input  logic signed [31:0]  value_c_i,
  input  logic signed [31:0]  value_d_i,
  output logic signed [31:0]  out_x_o,
  output logic signed [31:0]  out_y_o,
  output logic signed [31:0]  out_z_o,
  output logic signed [31:0]  out_w_o,
  output logic                saturated_o
);
  import m4t_pkg::*;

  localparam logic signed [ACC_W-1:0] MAX_S = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] MIN_S = ACC_W'(-64'sd2147483648);

  logic signed [DATA_W-1:0]   cur_q [16];
  logic signed [DATA_W-1:0]   opd_q [16];
  logic signed [DATA_W-1:0]   res_q [16];
  logic signed [DATA_W-1:0]   vec_q [4];
  logic [2:0]                 cmd_q;
  logic [3:0]                 idx_q;
  logic signed [2*DATA_W-1:0] prod_q [4];
  logic signed [2*DATA_W-1:0] prod_d [4];
  logic signed [ACC_W-1:0]    acc_q [4];
  logic signed [ACC_W-1:0]    sum_d [4];
  logic signed [DATA_W-1:0]   clip_d [4];
  logic [3:0]                 clip_sat;
  logic signed [DATA_W-1:0]   rhs_d;
  logic                       tv_q;
  logic [1:0]                 tcol_q;
  logic [1:0]                 tk_q;
  logic                       sat_q;
  logic signed [DATA_W-1:0]   out_q [4];
  logic                       out_sat_q;

  // right-hand element for the current column/step
  always_comb begin
    case (cmd_q)
      CMD_XFORM: rhs_d = vec_q[ctrl_i.k];
      CMD_MUL:   rhs_d = opd_q[{ctrl_i.col, ctrl_i.k}];
      default: begin
        if (ctrl_i.col == 2'd3 && ctrl_i.k != 2'd3) rhs_d = vec_q[ctrl_i.k];
        else if (ctrl_i.col == ctrl_i.k)               rhs_d = ONE_FX;
        else                                           rhs_d = '0;
      end
    endcase
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      prod_d[r] = cur_q[{ctrl_i.k, 2'(r)}] * rhs_d;
      sum_d[r]  = ((tk_q == 2'd0) ? ACC_W'(0) : acc_q[r])
                + ACC_W'(prod_q[r] >>> FRAC_BITS);
      clip_sat[r] = 1'b0;
      if (sum_d[r] > MAX_S) begin
        clip_d[r] = DATA_W'(MAX_S);
        clip_sat[r] = 1'b1;
      end else if (sum_d[r] < MIN_S) begin
        clip_d[r] = DATA_W'(MIN_S);
        clip_sat[r] = 1'b1;
      end else begin
        clip_d[r] = DATA_W'(sum_d[r]);
      end
    end
  end

  // control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= 1'b0;
      sat_q <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        cur_q[i] <= ((i % 4) == (i / 4)) ? ONE_FX : '0;
      end
    end else begin
      tv_q <= ctrl_i.issue;
      if (ctrl_i.load) begin
        sat_q <= 1'b0;
      end else if (tv_q && tk_q == 2'd3) begin
        sat_q <= sat_q | (|clip_sat);
      end
      if (ctrl_i.finish) begin
        case (cmd_q)
          CMD_WR_CUR: cur_q[idx_q] <= vec_q[0];
          CMD_IDENT: begin
            for (int i = 0; i < 16; i++) begin
              cur_q[i] <= ((i % 4) == (i / 4)) ? ONE_FX : '0;
            end
          end
          CMD_SETPOS: begin
            cur_q[12] <= vec_q[0];
            cur_q[13] <= vec_q[1];
            cur_q[14] <= vec_q[2];
          end
          CMD_TRANS, CMD_MUL: begin
            for (int i = 0; i < 16; i++) begin
              cur_q[i] <= res_q[i];
            end
          end
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q    <= cmd_i;
      idx_q    <= idx_i;
      vec_q[0] <= value_a_i;
      vec_q[1] <= value_b_i;
      vec_q[2] <= value_c_i;
      vec_q[3] <= value_d_i;
    end
    if (ctrl_i.issue) begin
      tcol_q <= ctrl_i.col;
      tk_q   <= ctrl_i.k;
      for (int r = 0; r < 4; r++) begin
        prod_q[r] <= prod_d[r];
      end
    end
    if (tv_q) begin
      for (int r = 0; r < 4; r++) begin
        acc_q[r] <= sum_d[r];
      end
      if (tk_q == 2'd3) begin
        for (int r = 0; r < 4; r++) begin
          res_q[{tcol_q, 2'(r)}] <= clip_d[r];
        end
      end
    end
    if (ctrl_i.finish) begin
      if (cmd_q == CMD_WR_OPD) opd_q[idx_q] <= vec_q[0];
      for (int r = 0; r < 4; r++) begin
        out_q[r] <= (cmd_q == CMD_XFORM) ? res_q[r] : '0;
      end
      out_sat_q <= sat_q;
    end
  end

  assign out_x_o     = out_q[0];
  assign out_y_o     = out_q[1];
  assign out_z_o     = out_q[2];
  assign out_w_o     = out_q[3];
  assign saturated_o = out_sat_q;

endmodule
`default_nettype wire

// ===== rtl/core/m4t_ctrl.sv =====
// controller: command sequencing and stream handshakes
`default_nettype none
module m4t_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic [2:0]        cmd_i,
  output logic              s_ready_o,
  input  logic              m_ready_i,
  output logic              m_valid_o,
  output m4t_pkg::ctrl_t    ctrl_o,
  output m4t_pkg::state_e   state_o
);
  import m4t_pkg::*;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       xf_q, xf_d;
  logic       vld_q, vld_d;
  logic       out_free;

  assign out_free = !vld_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      xf_q    <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      xf_q    <= xf_d;
      vld_q   <= vld_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    xf_d      = xf_q;
    vld_d     = vld_q && !m_ready_i;
    s_ready_o = 1'b0;
    ctrl_o    = '0;
    ctrl_o.col = xf_q ? 2'd0 : cnt_q[3:2];
    ctrl_o.k   = cnt_q[1:0];
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          ctrl_o.load = 1'b1;
          cnt_d = '0;
          xf_d  = (cmd_i == CMD_XFORM);
          if (cmd_i == CMD_XFORM || cmd_i == CMD_MUL || cmd_i == CMD_TRANS) begin
            state_d = ST_MAC;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_MAC: begin
        ctrl_o.issue = 1'b1;
        cnt_d = cnt_q + 4'd1;
        if ((xf_q && cnt_q == 4'd3) || cnt_q == 4'd15) state_d = ST_FLUSH;
      end
      ST_FLUSH: state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          ctrl_o.finish = 1'b1;
          vld_d   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_valid_o = vld_q;
  assign state_o   = state_q;

endmodule
`default_nettype wire

// ===== rtl/core/matrix4_transform_unit.sv =====
// top level: 4x4 q16.16 matrix transform unit with stream ports
// sequence: load, then finish for writes, identity and set position; transform
// runs one mac step per element, translate and matrix multiply 16 steps of four
// mac lanes, flush, finish; one item at a time, next accepted the cycle after finish
// reset: asynchronous active low, current matrix to identity, operand matrix undefined
`default_nettype none
module matrix4_transform_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [135:0] s_axis_tdata_i,  // elem_index, value_a, value_b, value_c, value_d
  input  logic [2:0]   s_axis_tuser_i,  // cmd
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o,  // out_x, out_y, out_z, out_w
  output logic         m_axis_tuser_o   // saturated
);
  import m4t_pkg::*;

  ctrl_t  ctrl;
  state_e state;
  logic signed [31:0] ox, oy, oz, ow;

  m4t_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .cmd_i     (s_axis_tuser_i),
    .s_ready_o (s_axis_tready_o),
    .m_ready_i (m_axis_tready_i),
    .m_valid_o (m_axis_tvalid_o),
    .ctrl_o    (ctrl),
    .state_o   (state)
  );

  m4t_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cmd_i       (s_axis_tuser_i),
    .idx_i       (s_axis_tdata_i[3:0]),
    .value_a_i   (s_axis_tdata_i[35:4]),
    .value_b_i   (s_axis_tdata_i[67:36]),
    .value_c_i   (s_axis_tdata_i[99:68]),
    .value_d_i   (s_axis_tdata_i[131:100]),
    .out_x_o     (ox),
    .out_y_o     (oy),
    .out_z_o     (oz),
    .out_w_o     (ow),
    .saturated_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {ow, oz, oy, ox};

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted twice in a row");

  a_issue_in_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.issue |-> (state == ST_MAC))
    else $error("mac issue outside mac state");

  a_finish_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.finish |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result overwrote a pending transfer");

endmodule
`default_nettype wire
